>>> design/histogram_mode_level_classifier_defines.svh
// Assertion helpers for the histogram mode level classifier.
`ifndef HISTOGRAM_MODE_LEVEL_CLASSIFIER_DEFINES_SVH
`define HISTOGRAM_MODE_LEVEL_CLASSIFIER_DEFINES_SVH

`ifndef SYNTHESIS

// Checks a property on every rising clock edge outside reset.
`define HMLC_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("hmlc assertion failed");

// Checks that a condition never holds outside reset.
`define HMLC_ASSERT_NEVER(lbl, clk, rst_n, cond) \
  `HMLC_ASSERT(lbl, clk, rst_n, !(cond))

`else

`define HMLC_ASSERT(lbl, clk, rst_n, prop)
`define HMLC_ASSERT_NEVER(lbl, clk, rst_n, cond)

`endif

`endif

>>> design/hmlc_pkg.sv
package hmlc_pkg;

  // Field and storage widths.
  localparam int SampleWidth    = 10;
  localparam int SampleBits     = 10;
  localparam int BinCount       = 1 << SampleBits;
  localparam int CountWidth     = 8;
  localparam int LevelWidth     = 10;
  localparam int WindowWidth    = 10;
  localparam int GearWidth      = 4;
  localparam int EntryGearWidth = 3;
  localparam int LevelEntries   = 7;
  localparam int IdxBits        = (LevelEntries > 1) ? $clog2(LevelEntries) : 1;

  // Packed register widths.
  localparam int LowPackWidth   = 40;
  localparam int HighPackWidth  = 30;
  localparam int GearPackWidth  = 21;
  localparam int AllLevelsWidth = LowPackWidth + HighPackWidth;

  // Configuration channel.
  localparam int CfgIdxWidth  = 3;
  localparam int CfgDataWidth = 40;

  // Register reset values.
  localparam logic [CountWidth-1:0]    PeakCountRst   = 8'd8;
  localparam logic [WindowWidth-1:0]   MatchWindowRst = 10'd20;
  localparam logic [LowPackWidth-1:0]  LevelsLowRst   = 40'd659765067120;
  localparam logic [HighPackWidth-1:0] LevelsHighRst  = 30'd1007548139;
  localparam logic [GearPackWidth-1:0] GearPackRst    = 21'd1754753;

  // Gear code for no match.
  localparam logic [GearWidth-1:0] NoGear = 4'hF;

  typedef enum logic [CfgIdxWidth-1:0] {
    CfgPeakCount   = 3'd0,
    CfgMatchWindow = 3'd1,
    CfgLevelsLow   = 3'd2,
    CfgLevelsHigh  = 3'd3,
    CfgGearPack    = 3'd4
  } cfg_reg_e;

  typedef enum logic [2:0] {
    StClear,
    StIdle,
    StUpdate,
    StClassify,
    StEmit
  } state_e;

endpackage

>>> design/hmlc_if.sv
// Sample input channel.
interface hmlc_sample_if import hmlc_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [SampleWidth-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

// Gear result channel.
interface hmlc_result_if import hmlc_pkg::*; ();
  logic                         valid;
  logic                         ready;
  logic signed [GearWidth-1:0]  gear;
  logic        [LevelWidth-1:0] settled_level;

  modport source (output valid, output gear, output settled_level, input ready);
  modport sink   (input valid, input gear, input settled_level, output ready);
endinterface

// Configuration write channel.
interface hmlc_cfg_if import hmlc_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [CfgIdxWidth-1:0]  index;
  logic [CfgDataWidth-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

>>> design/hmlc_ram.sv
// Simple dual-port RAM: one write port, one read port with registered data.
module hmlc_ram #(
  parameter int Width = 8,
  parameter int Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

>>> design/histogram_mode_level_classifier.sv
// Histogram mode level classifier. Each accepted sample passes the idle state,
// where the histogram RAM is read, and the update state, where the bin gets its
// read-modify-write. When a bin reaches the peak count, the settled level is
// compared with the stored voltages one entry per cycle through a single window
// comparator (up to seven entries), the emit state decides and loads the
// result, and a clearing pass then zeroes all 1024 bins at one bin per cycle.
// The same clearing pass runs after reset. Samples are not accepted during
// classification or clearing; configuration writes are taken at any time. A
// waiting result holds back the next result and, meanwhile, the sample input.
`include "histogram_mode_level_classifier_defines.svh"

module histogram_mode_level_classifier import hmlc_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  hmlc_sample_if.sink     sample_i,
  hmlc_result_if.source   result_o,
  hmlc_cfg_if.sink        cfg_i
);

  state_e state_q, state_d;

  // Configuration registers.
  logic [CountWidth-1:0]    peak_count_q;
  logic [WindowWidth-1:0]   match_window_q;
  logic [LowPackWidth-1:0]  levels_low_q;
  logic [HighPackWidth-1:0] levels_high_q;
  logic [GearPackWidth-1:0] gear_pack_q;

  // Sequencer and datapath registers.
  logic [SampleBits-1:0] clr_q, clr_d;
  logic [SampleBits-1:0] bin_q, bin_d;
  logic [IdxBits-1:0]    idx_q, idx_d;
  logic [GearWidth-1:0]  found_q, found_d;
  logic [GearWidth-1:0]  current_gear_q, current_gear_d;
  logic                  out_valid_q, out_valid_d;
  logic [GearWidth-1:0]  out_gear_q, out_gear_d;
  logic [LevelWidth-1:0] out_level_q, out_level_d;

  // RAM signals.
  logic                  ram_we;
  logic [SampleBits-1:0] ram_waddr;
  logic [CountWidth-1:0] ram_wdata;
  logic [CountWidth-1:0] ram_rdata;

  logic                  in_xfer;
  logic [CountWidth-1:0] bin_next;
  logic                  settled;
  logic                  last_entry;
  logic                  slot_free;
  logic                  new_gear;
  logic                  load_result;

  // Window comparator.
  logic [AllLevelsWidth-1:0] all_levels;
  logic [LevelWidth-1:0]     entry_level;
  logic [EntryGearWidth-1:0] entry_gear;
  logic [LevelWidth:0]       diff;
  logic [LevelWidth:0]       mag;
  logic                      in_window;

  hmlc_ram #(
    .Width (CountWidth),
    .Depth (BinCount)
  ) u_bins (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (sample_i.sample[SampleBits-1:0]),
    .rdata_o (ram_rdata)
  );

  assign in_xfer    = sample_i.valid && sample_i.ready;
  assign bin_next   = ram_rdata + CountWidth'(1);
  assign settled    = (bin_next == peak_count_q);
  assign last_entry = (idx_q == IdxBits'(LevelEntries - 1));
  assign slot_free  = !out_valid_q || result_o.ready;
  assign new_gear   = (found_q != current_gear_q);

  // One entry per cycle: |level - voltage| < window.
  assign all_levels  = {levels_high_q, levels_low_q};
  assign entry_level = all_levels[idx_q * LevelWidth +: LevelWidth];
  assign entry_gear  = gear_pack_q[idx_q * EntryGearWidth +: EntryGearWidth];
  assign diff        = {1'b0, LevelWidth'(bin_q)} - {1'b0, entry_level};
  assign mag         = diff[LevelWidth] ? (~diff + (LevelWidth + 1)'(1)) : diff;
  assign in_window   = (mag < {1'b0, match_window_q});

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      StClear: begin
        if (clr_q == SampleBits'(BinCount - 1)) begin
          state_d = StIdle;
        end
      end
      StIdle: begin
        if (in_xfer) begin
          state_d = StUpdate;
        end
      end
      StUpdate: begin
        state_d = settled ? StClassify : StIdle;
      end
      StClassify: begin
        if (in_window || last_entry) begin
          state_d = StEmit;
        end
      end
      StEmit: begin
        if (!new_gear || slot_free) begin
          state_d = StClear;
        end
      end
      default: state_d = StClear;
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    sample_i.ready = 1'b0;
    ram_we         = 1'b0;
    ram_waddr      = bin_q;
    ram_wdata      = bin_next;
    load_result    = 1'b0;
    case (state_q)
      StClear: begin
        ram_we    = 1'b1;
        ram_waddr = clr_q;
        ram_wdata = '0;
      end
      StIdle: begin
        sample_i.ready = 1'b1;
      end
      StUpdate: begin
        ram_we = 1'b1;
      end
      StEmit: begin
        load_result = new_gear && slot_free;
      end
      default: begin
      end
    endcase
  end

  // Datapath next values.
  always_comb begin
    clr_d          = clr_q;
    bin_d          = bin_q;
    idx_d          = idx_q;
    found_d        = found_q;
    current_gear_d = current_gear_q;
    out_valid_d    = out_valid_q && !result_o.ready;
    out_gear_d     = out_gear_q;
    out_level_d    = out_level_q;

    if (state_q == StClear) begin
      clr_d = clr_q + SampleBits'(1);
    end
    if (in_xfer) begin
      bin_d = sample_i.sample[SampleBits-1:0];
    end
    if (state_q == StUpdate) begin
      idx_d   = '0;
      found_d = NoGear;
    end
    if (state_q == StClassify) begin
      idx_d = idx_q + IdxBits'(1);
      if (in_window) begin
        found_d = {1'b0, entry_gear};
      end
    end
    if (state_q == StEmit) begin
      clr_d = '0;
    end
    if (load_result) begin
      current_gear_d = found_q;
      out_valid_d    = 1'b1;
      out_gear_d     = found_q;
      out_level_d    = LevelWidth'(bin_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= StClear;
      clr_q          <= '0;
      idx_q          <= '0;
      found_q        <= NoGear;
      current_gear_q <= NoGear;
      out_valid_q    <= 1'b0;
    end else begin
      state_q        <= state_d;
      clr_q          <= clr_d;
      idx_q          <= idx_d;
      found_q        <= found_d;
      current_gear_q <= current_gear_d;
      out_valid_q    <= out_valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    bin_q       <= bin_d;
    out_gear_q  <= out_gear_d;
    out_level_q <= out_level_d;
  end

  // Configuration writes; indexes beyond the list are dropped.
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      peak_count_q   <= PeakCountRst;
      match_window_q <= MatchWindowRst;
      levels_low_q   <= LevelsLowRst;
      levels_high_q  <= LevelsHighRst;
      gear_pack_q    <= GearPackRst;
    end else if (cfg_i.valid && cfg_i.ready) begin
      case (cfg_i.index)
        CfgPeakCount:   peak_count_q   <= cfg_i.data[CountWidth-1:0];
        CfgMatchWindow: match_window_q <= cfg_i.data[WindowWidth-1:0];
        CfgLevelsLow:   levels_low_q   <= cfg_i.data[LowPackWidth-1:0];
        CfgLevelsHigh:  levels_high_q  <= cfg_i.data[HighPackWidth-1:0];
        CfgGearPack:    gear_pack_q    <= cfg_i.data[GearPackWidth-1:0];
        default: begin
        end
      endcase
    end
  end

  assign result_o.valid         = out_valid_q;
  assign result_o.gear          = $signed(out_gear_q);
  assign result_o.settled_level = out_level_q;

  // The last bin of a clearing pass always returns to idle.
  `HMLC_ASSERT(clear_ends_idle_a, clk_i, rst_ni,
    (state_q == StClear && clr_q == SampleBits'(BinCount - 1)) |=> (state_q == StIdle))
  // The entry index stays inside the stored table while classifying.
  `HMLC_ASSERT_NEVER(idx_range_a, clk_i, rst_ni,
    state_q == StClassify && idx_q > IdxBits'(LevelEntries - 1))
  // A fresh result carries the gear that is now current.
  `HMLC_ASSERT(result_is_current_a, clk_i, rst_ni,
    $rose(out_valid_q) |-> (out_gear_q == current_gear_q))
  // A fresh result always marks a gear change.
  `HMLC_ASSERT(result_changes_gear_a, clk_i, rst_ni,
    $rose(out_valid_q) |-> ($past(current_gear_q) != current_gear_q))

endmodule

>>> sim/testbench.sv
`timescale 1ns / 1ps

module testbench import hmlc_pkg::*; ();

  localparam int HoldCycles    = 3000;
  localparam int IdleTail      = 1200;
  localparam int WatchLimit    = 20000;
  localparam int MinBlocks     = 9;
  localparam int PressureBlock = 7;

  // One gear change as the block reports it.
  typedef struct packed {
    logic signed [GearWidth-1:0] gear;
    logic [LevelWidth-1:0]       level;
  } gear_report_t;

  // Histogram and gear tracker that predicts every gear report.
  class gear_scoreboard;
    logic [CountWidth-1:0]       bin_hits [BinCount];
    logic signed [GearWidth-1:0] gear_now;
    logic [CountWidth-1:0]       peak;
    logic [WindowWidth-1:0]      window;
    logic [LowPackWidth-1:0]     levels_low;
    logic [HighPackWidth-1:0]    levels_high;
    logic [GearPackWidth-1:0]    gears;
    gear_report_t                expected_gears[$];
    int errors;
    int samples;
    int settles;
    int reports;

    function new();
      foreach (bin_hits[i]) bin_hits[i] = '0;
      gear_now    = $signed(NoGear);
      peak        = PeakCountRst;
      window      = MatchWindowRst;
      levels_low  = LevelsLowRst;
      levels_high = LevelsHighRst;
      gears       = GearPackRst;
      errors      = 0;
      samples     = 0;
      settles     = 0;
      reports     = 0;
    endfunction

    function void write_reg(logic [CfgIdxWidth-1:0] idx, logic [CfgDataWidth-1:0] d);
      case (idx)
        CfgPeakCount:   peak        = d[CountWidth-1:0];
        CfgMatchWindow: window      = d[WindowWidth-1:0];
        CfgLevelsLow:   levels_low  = d[LowPackWidth-1:0];
        CfgLevelsHigh:  levels_high = d[HighPackWidth-1:0];
        CfgGearPack:    gears       = d[GearPackWidth-1:0];
        default: ;
      endcase
    endfunction

    function logic [LevelWidth-1:0] entry_level(int i);
      if (i < 4) return levels_low[LevelWidth*i +: LevelWidth];
      return levels_high[LevelWidth*(i-4) +: LevelWidth];
    endfunction

    // The first entry whose voltage lies strictly inside the window wins.
    function logic signed [GearWidth-1:0] gear_of(int level);
      int w;
      int v;
      w = int'(window);
      for (int i = 0; i < LevelEntries; i++) begin
        v = int'(entry_level(i));
        if (level - w < v && level + w > v)
          return $signed({1'b0, gears[EntryGearWidth*i +: EntryGearWidth]});
      end
      return $signed(NoGear);
    endfunction

    // Counts one accepted sample and queues a report when the gear changes.
    function void count_sample(logic [SampleWidth-1:0] s);
      logic [SampleBits-1:0]       bin;
      logic signed [GearWidth-1:0] g;
      gear_report_t                r;
      bin = s[SampleBits-1:0];
      samples++;
      bin_hits[bin] = bin_hits[bin] + 1'b1;
      if (bin_hits[bin] != peak) return;
      foreach (bin_hits[i]) bin_hits[i] = '0;
      settles++;
      g = gear_of(int'(bin));
      if (g == gear_now) return;
      gear_now = g;
      r.gear   = g;
      r.level  = LevelWidth'(bin);
      expected_gears.push_back(r);
    endfunction

    function int waiting();
      return expected_gears.size();
    endfunction

    function void check_report(logic signed [GearWidth-1:0] gear, logic [LevelWidth-1:0] level);
      gear_report_t want;
      if (expected_gears.size() == 0) begin
        $display("%0t: unexpected report, expected none, actual gear %0d level %0d",
                 $time, gear, level);
        errors++;
        return;
      end
      want = expected_gears.pop_front();
      reports++;
      if (gear !== want.gear) begin
        $display("%0t: gear mismatch, expected %0d, actual %0d", $time, want.gear, gear);
        errors++;
      end
      if (level !== want.level) begin
        $display("%0t: settled level mismatch, expected %0d, actual %0d",
                 $time, want.level, level);
        errors++;
      end
    endfunction

    function void close_out();
      foreach (expected_gears[i]) begin
        $display("%0t: expected gear %0d level %0d never arrived, actual none",
                 $time, expected_gears[i].gear, expected_gears[i].level);
        errors++;
      end
    endfunction
  endclass

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  hmlc_sample_if smp ();
  hmlc_result_if res ();
  hmlc_cfg_if    cfg ();

  histogram_mode_level_classifier dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .sample_i (smp),
    .result_o (res),
    .cfg_i    (cfg)
  );

  gear_scoreboard sb;
  int  send_idle_pct = 23;
  int  recv_idle_pct = 71;
  bit  hold_req = 1'b0;
  int  holds = 0;
  int  settings = 0;
  int  quiet = 0;

  // Free-running clock, 10 ns period.
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Watchdog: ends the run after a long stretch without any transfer.
  always @(posedge clk_i) begin
    if (!rst_ni || (smp.valid && smp.ready) || (res.valid && res.ready) ||
        (cfg.valid && cfg.ready)) begin
      quiet <= 0;
    end else if (quiet >= WatchLimit) begin
      $display("%0t: watchdog, no transfer for %0d cycles", $time, quiet);
      $display("Regression FAIL");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  // Result receiver: checks each transfer and throttles ready.
  initial begin
    res.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (res.valid && res.ready) sb.check_report(res.gear, res.settled_level);
      if (hold_req) begin
        // Long hold-off so that a report backs up and the input stalls.
        res.ready <= 1'b0;
        hold_req = 1'b0;
        holds++;
        repeat (HoldCycles) @(posedge clk_i);
      end else begin
        res.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Offers one sample, with an optional random gap first.
  task automatic send_sample(input logic [SampleWidth-1:0] s);
    if ($urandom_range(99) < send_idle_pct) begin
      smp.valid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
    smp.valid  <= 1'b1;
    smp.sample <= s;
    do @(posedge clk_i); while (!smp.ready);
    sb.count_sample(s);
  endtask

  task automatic write_reg(input logic [CfgIdxWidth-1:0] idx,
                           input logic [CfgDataWidth-1:0] d);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data  <= d;
    do @(posedge clk_i); while (!cfg.ready);
    sb.write_reg(idx, d);
  endtask

  // Writes all five registers; unused data bits carry random junk.
  task automatic apply_settings(input logic [CountWidth-1:0]    pk,
                                input logic [WindowWidth-1:0]   win,
                                input logic [LowPackWidth-1:0]  low,
                                input logic [HighPackWidth-1:0] high,
                                input logic [GearPackWidth-1:0] gp);
    logic [CfgDataWidth-1:0] junk;
    junk = CfgDataWidth'({$urandom(), $urandom()});
    write_reg(CfgPeakCount, {junk[CfgDataWidth-1:CountWidth], pk});
    write_reg(CfgMatchWindow, {junk[CfgDataWidth-1:WindowWidth], win});
    write_reg(CfgLevelsLow, low);
    write_reg(CfgLevelsHigh, {junk[CfgDataWidth-1:HighPackWidth], high});
    write_reg(CfgGearPack, {junk[CfgDataWidth-1:GearPackWidth], gp});
    cfg.valid <= 1'b0;
    settings++;
  endtask

  // Waits for every expected report, then for the block to finish clearing.
  task automatic drain_and_rest();
    smp.valid <= 1'b0;
    while (sb.waiting() > 0) @(posedge clk_i);
    repeat (IdleTail) @(posedge clk_i);
  endtask

  function automatic logic [SampleWidth-1:0] clamp_level(int x);
    if (x < 0) return '0;
    if (x > BinCount - 1) return SampleWidth'(BinCount - 1);
    return SampleWidth'(x);
  endfunction

  // Target level: mostly around a stored voltage, else anywhere or an extreme.
  function automatic logic [SampleWidth-1:0] pick_level();
    int r;
    int w;
    int v;
    r = $urandom_range(99);
    if (r < 60) begin
      v = int'(sb.entry_level($urandom_range(LevelEntries - 1)));
      w = int'(sb.window);
      return clamp_level(v + int'($urandom_range(2 * w + 4)) - (w + 2));
    end
    if (r < 80) return SampleWidth'($urandom_range(BinCount - 1));
    if (r < 90) return '0;
    return SampleWidth'(BinCount - 1);
  endfunction

  // One settling run: repeated hits on one level mixed with noise.
  task automatic run_sequence();
    logic [SampleWidth-1:0] lvl;
    int hits;
    int noise;
    lvl  = pick_level();
    hits = (sb.peak == 0) ? 256 : int'(sb.peak);
    // Some runs stop one hit short of settling.
    if ($urandom_range(99) < 15) hits = hits - 1;
    noise = (hits > 32) ? 5 : 25;
    while (hits > 0) begin
      if ($urandom_range(99) < noise) begin
        send_sample(SampleWidth'($urandom_range(BinCount - 1)));
      end else begin
        send_sample(lvl);
        hits--;
      end
    end
  endtask

  task automatic run_block(input int blk);
    logic [CountWidth-1:0]    pk;
    logic [WindowWidth-1:0]   win;
    logic [LowPackWidth-1:0]  low;
    logic [HighPackWidth-1:0] high;
    int r;
    int start;
    int quota;
    if (blk == 2) pk = '0;
    else if (blk == 4) pk = 8'd255;
    else if (blk % 3 == 0) pk = 8'd1;
    else pk = CountWidth'($urandom_range(10, 2));
    r = $urandom_range(99);
    if (r < 10) win = '0;
    else if (r < 20) win = 10'd1023;
    else win = WindowWidth'($urandom_range(60, 4));
    if ($urandom_range(1)) begin
      low  = LevelsLowRst;
      high = LevelsHighRst;
    end else begin
      low  = LowPackWidth'({$urandom(), $urandom()});
      high = HighPackWidth'($urandom());
    end
    apply_settings(pk, win, low, high, GearPackWidth'($urandom()));
    if (blk == PressureBlock) hold_req = 1'b1;
    // A peak of one settles on every sample, which makes each one slow.
    quota = (pk == 8'd1) ? 30 : 20;
    start = sb.samples;
    while (sb.samples - start < quota) run_sequence();
    drain_and_rest();
  endtask

  // Short directed part: extremes, window edges, window zero, gear seven.
  task automatic directed_part();
    int w;
    write_reg(CfgIdxWidth'($urandom_range(7, CfgGearPack + 1)),
              CfgDataWidth'({$urandom(), $urandom()}));
    apply_settings(8'd1, 10'd20, LevelsLowRst, LevelsHighRst, GearPackRst);
    w = int'(sb.window);
    send_sample('0);
    send_sample(SampleWidth'(BinCount - 1));
    send_sample(sb.entry_level(0));
    send_sample(sb.entry_level(0));
    send_sample(clamp_level(int'(sb.entry_level(1)) + w - 1));
    send_sample(clamp_level(int'(sb.entry_level(2)) - w + 1));
    send_sample(clamp_level(int'(sb.entry_level(3)) + w));
    send_sample(clamp_level(int'(sb.entry_level(4)) - w));
    send_sample(sb.entry_level(5));
    send_sample(sb.entry_level(6));
    drain_and_rest();

    // With a zero window nothing can match.
    apply_settings(8'd1, '0, LevelsLowRst, LevelsHighRst, GearPackRst);
    send_sample(sb.entry_level(0));
    send_sample(sb.entry_level(3));
    drain_and_rest();

    // Widest window and every entry mapped to gear seven.
    apply_settings(8'd1, 10'd1023, LevelsLowRst, LevelsHighRst, '1);
    send_sample(SampleWidth'(512));
    send_sample('0);
    send_sample(SampleWidth'(BinCount - 1));
    drain_and_rest();

    apply_settings(8'd2, 10'd5, LowPackWidth'({$urandom(), $urandom()}),
                   HighPackWidth'($urandom()), GearPackWidth'($urandom()));
    send_sample(SampleWidth'(700));
    send_sample(SampleWidth'(700));
    send_sample(SampleWidth'(5));
    send_sample(SampleWidth'(5));
    drain_and_rest();
  endtask

  // Main stimulus thread.
  initial begin
    int blk;
    sb = new();
    smp.valid  <= 1'b0;
    smp.sample <= '0;
    cfg.valid  <= 1'b0;
    cfg.index  <= '0;
    cfg.data   <= '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    directed_part();

    blk = 0;
    while (blk < MinBlocks) begin
      if (blk < 3) begin
        send_idle_pct = 23;
        recv_idle_pct = 71;
      end else if (blk < 6) begin
        send_idle_pct = 71;
        recv_idle_pct = 23;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      run_block(blk);
      blk++;
    end

    sb.close_out();
    $display("Covered %0d samples, %0d settled levels and %0d gear reports over %0d settings.",
             sb.samples, sb.settles, sb.reports, settings);
    $display("Ran three idle profiles and %0d long receiver hold-off(s).", holds);
    if (sb.errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
